@@ hdl/radar_measurement_jacobian_macros.svh @@
// Assertion shorthands for the radar Jacobian block.
`ifndef RADAR_MEASUREMENT_JACOBIAN_MACROS_SVH
`define RADAR_MEASUREMENT_JACOBIAN_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define RMJ_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define RMJ_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

`endif

@@ hdl/rmj_pkg.sv @@
package rmj_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W = 32;
  localparam int E_W = 5;
  localparam int NORM_STEPS = 5;
  localparam int SQRT_STEPS = 32;
  localparam int SQ_RW = 34;
  localparam int SQ_QW = 32;
  localparam int UDIV_STEPS = 33;
  localparam int WDIV_STEPS = 64;
  localparam int MAG_W = 66;

  typedef struct packed {
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
  } req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] range_dpx;
    logic signed [VAL_W-1:0] range_dpy;
    logic signed [VAL_W-1:0] bearing_dpx;
    logic signed [VAL_W-1:0] bearing_dpy;
    logic signed [VAL_W-1:0] rate_dpx;
    logic signed [VAL_W-1:0] rate_dpy;
    logic signed [VAL_W-1:0] rate_dvx;
    logic signed [VAL_W-1:0] rate_dvy;
    logic                    zero_position;
    logic                    saturated;
  } jac_t;

  typedef struct packed {
    logic zero;
    logic neg_x;
    logic neg_y;
    logic c_neg;
  } flags_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic             sat;
  } pack_t;

  function automatic pack_t sat_pack(logic [MAG_W-1:0] mag, logic neg, logic ovf);
    pack_t r;
    if (neg) begin
      if (ovf || mag > {{(MAG_W-VAL_W){1'b0}}, 32'h8000_0000}) begin
        r.val = 32'h8000_0000;
        r.sat = 1'b1;
      end else begin
        r.val = 32'd0 - mag[VAL_W-1:0];
        r.sat = 1'b0;
      end
    end else begin
      if (ovf || mag > {{(MAG_W-VAL_W){1'b0}}, 32'h7FFF_FFFF}) begin
        r.val = 32'h7FFF_FFFF;
        r.sat = 1'b1;
      end else begin
        r.val = mag[VAL_W-1:0];
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/rmj_delay.sv @@
module rmj_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

@@ hdl/rmj_norm_cell.sv @@
module rmj_norm_cell #(
  parameter int SH = 32,
  parameter int SW = 1
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [63:0]               x_in,
  input  logic [rmj_pkg::E_W-1:0]   e_in,
  input  logic [SW-1:0]             side_in,
  output logic [63:0]               x_out,
  output logic [rmj_pkg::E_W-1:0]   e_out,
  output logic [SW-1:0]             side_out
);

  localparam int EW = rmj_pkg::E_W;

  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in[63 -: SH] == '0) begin
        x_out <= x_in << SH;
        e_out <= e_in + EW'(SH / 2);
      end else begin
        x_out <= x_in;
        e_out <= e_in;
      end
      side_out <= side_in;
    end
  end

endmodule

@@ hdl/rmj_sqrt_cell.sv @@
module rmj_sqrt_cell #(
  parameter int SW = 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [63:0]                 x_in,
  input  logic [rmj_pkg::SQ_RW-1:0]   r_in,
  input  logic [rmj_pkg::SQ_QW-1:0]   q_in,
  input  logic [SW-1:0]               side_in,
  output logic [63:0]                 x_out,
  output logic [rmj_pkg::SQ_RW-1:0]   r_out,
  output logic [rmj_pkg::SQ_QW-1:0]   q_out,
  output logic [SW-1:0]               side_out
);

  localparam int RW = rmj_pkg::SQ_RW;
  localparam int QW = rmj_pkg::SQ_QW;

  logic [RW+1:0] r2;
  logic [RW+1:0] trial;
  logic [RW+1:0] diff;
  logic          ge;

  assign r2    = {r_in, x_in[63:62]};
  assign trial = {{(RW-QW){1'b0}}, q_in, 2'b01};
  assign ge    = r2 >= trial;
  assign diff  = r2 - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_in << 2;
      r_out    <= ge ? diff[RW-1:0] : r2[RW-1:0];
      q_out    <= {q_in[QW-2:0], ge};
      side_out <= side_in;
    end
  end

endmodule

@@ hdl/rmj_div_cell.sv @@
module rmj_div_cell #(
  parameter int DW = 32,
  parameter int NW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] r_in,
  input  logic [DW-1:0] d_in,
  input  logic [NW-1:0] n_in,
  input  logic [QW-1:0] q_in,
  output logic [DW-1:0] r_out,
  output logic [DW-1:0] d_out,
  output logic [NW-1:0] n_out,
  output logic [QW-1:0] q_out
);

  logic [DW:0] r2;
  logic [DW:0] diff;
  logic        ge;

  assign r2   = {r_in, n_in[NW-1]};
  assign ge   = r2 >= {1'b0, d_in};
  assign diff = r2 - {1'b0, d_in};

  always_ff @(posedge clk) begin
    if (en) begin
      r_out <= ge ? diff[DW-1:0] : r2[DW-1:0];
      d_out <= d_in;
      n_out <= n_in << 1;
      q_out <= {q_in[QW-2:0], ge};
    end
  end

endmodule

@@ hdl/radar_measurement_jacobian.sv @@
// Radar measurement Jacobian for an extended Kalman filter, fixed point.
// Request channel (req_valid / req_ready / req) takes a state vector
// pos_x, pos_y, vel_x, vel_y, each signed Q(32-FRAC_BITS).FRAC_BITS.
// Result channel (jac_valid / jac_ready / jac) returns the range, bearing
// and range-rate partials, a zero-position flag and a saturation flag.
// One result per request, in order. Throughput is one request per cycle
// while the output is not stalled. The pipeline is a chain of cells: 5
// normalize steps, 32 square-root steps and 33 divide steps (one bit per
// square-root or divide cell), plus front-end multiply/add and back-end
// multiply/saturate stages. Bearing and range-rate quotients run in
// parallel chains and are delayed to line up with the main chain.
// Reset clears the valid bits of the pipeline; no result is pending after
// reset. When jac_valid is high and jac_ready is low the whole pipeline
// holds and req_ready drops in the same cycle; it advances as soon as the
// result is taken.
`include "radar_measurement_jacobian_macros.svh"

module radar_measurement_jacobian #(
  parameter int FRAC_BITS = rmj_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rmj_pkg::req_t  req,
  output logic           jac_valid,
  input  logic           jac_ready,
  output rmj_pkg::jac_t  jac
);

  localparam int EW     = rmj_pkg::E_W;
  localparam int NSTEP  = rmj_pkg::NORM_STEPS;
  localparam int SSTEP  = rmj_pkg::SQRT_STEPS;
  localparam int USTEP  = rmj_pkg::UDIV_STEPS;
  localparam int WSTEP  = rmj_pkg::WDIV_STEPS;
  localparam int MW     = rmj_pkg::MAG_W;
  localparam int RW     = rmj_pkg::SQ_RW;
  localparam int QW     = rmj_pkg::SQ_QW;
  localparam int BQW    = 2 * FRAC_BITS + 1;
  localparam int RSH    = 32 - FRAC_BITS;
  localparam int SSW    = EW + 64;
  localparam int S_P    = 2;
  localparam int S_SQ   = S_P + NSTEP + SSTEP;
  localparam int S_U    = S_SQ + 1 + USTEP;
  localparam int S_W    = S_P + 1 + WSTEP;
  localparam int S_B    = S_P + BQW;
  localparam int LAT    = S_U + 2;
  localparam int W_DLY  = S_U - S_W;
  localparam int WO_DLY = S_U - S_P - 1;
  localparam int B_DLY  = S_U - S_B;
  localparam int F_DLY  = S_U - S_P;

  logic [LAT:1] vld;
  logic         en;

  assign en        = !vld[LAT] || jac_ready;
  assign req_ready = en && !rst;
  assign jac_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], req_valid};
    end
  end

  // front end: magnitudes, squares, cross products
  logic [31:0]        apx_in, apy_in;
  logic [63:0]        s1_sqx, s1_sqy;
  logic signed [63:0] s1_t1, s1_t2;
  logic [31:0]        s1_apx, s1_apy;
  logic               s1_zero, s1_nx, s1_ny;

  assign apx_in = req.pos_x[31] ? (~req.pos_x + 32'd1) : req.pos_x;
  assign apy_in = req.pos_y[31] ? (~req.pos_y + 32'd1) : req.pos_y;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sqx  <= apx_in * apx_in;
      s1_sqy  <= apy_in * apy_in;
      s1_t1   <= req.vel_x * req.pos_y;
      s1_t2   <= req.vel_y * req.pos_x;
      s1_apx  <= apx_in;
      s1_apy  <= apy_in;
      s1_zero <= (req.pos_x == '0) && (req.pos_y == '0);
      s1_nx   <= req.pos_x[31];
      s1_ny   <= req.pos_y[31];
    end
  end

  logic [63:0]     s2_p, s2_cmag;
  logic [31:0]     s2_apx, s2_apy;
  rmj_pkg::flags_t s2_flags;
  logic            c_neg1;

  assign c_neg1 = s1_t1 < s1_t2;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p     <= s1_sqx + s1_sqy;
      s2_cmag  <= c_neg1 ? 64'(s1_t2 - s1_t1) : 64'(s1_t1 - s1_t2);
      s2_apx   <= s1_apx;
      s2_apy   <= s1_apy;
      s2_flags <= '{zero: s1_zero, neg_x: s1_nx, neg_y: s1_ny, c_neg: c_neg1};
    end
  end

  // normalize r2 to the top two bits
  logic [63:0]   nm_x    [0:NSTEP];
  logic [EW-1:0] nm_e    [0:NSTEP];
  logic [63:0]   nm_side [0:NSTEP];

  assign nm_x[0]    = s2_p;
  assign nm_e[0]    = '0;
  assign nm_side[0] = {s2_apx, s2_apy};

  for (genvar k = 0; k < NSTEP; k++) begin : g_norm
    rmj_norm_cell #(.SH(32 >> k), .SW(64)) u_cell (
      .clk(clk), .en(en),
      .x_in(nm_x[k]), .e_in(nm_e[k]), .side_in(nm_side[k]),
      .x_out(nm_x[k+1]), .e_out(nm_e[k+1]), .side_out(nm_side[k+1])
    );
  end

  // square root, one root bit per cell
  logic [63:0]    sq_x    [0:SSTEP];
  logic [RW-1:0]  sq_r    [0:SSTEP];
  logic [QW-1:0]  sq_q    [0:SSTEP];
  logic [SSW-1:0] sq_side [0:SSTEP];

  assign sq_x[0]    = nm_x[NSTEP];
  assign sq_r[0]    = '0;
  assign sq_q[0]    = '0;
  assign sq_side[0] = {nm_e[NSTEP], nm_side[NSTEP]};

  for (genvar k = 0; k < SSTEP; k++) begin : g_sqrt
    rmj_sqrt_cell #(.SW(SSW)) u_cell (
      .clk(clk), .en(en),
      .x_in(sq_x[k]), .r_in(sq_r[k]), .q_in(sq_q[k]), .side_in(sq_side[k]),
      .x_out(sq_x[k+1]), .r_out(sq_r[k+1]), .q_out(sq_q[k+1]),
      .side_out(sq_side[k+1])
    );
  end

  // scale positions by 2^e for the range quotients
  logic [63:0] shx, shy;
  logic [31:0] sh_ax, sh_ay, sh_s;

  assign shx = {32'd0, sq_side[SSTEP][63:32]} << sq_side[SSTEP][SSW-1:64];
  assign shy = {32'd0, sq_side[SSTEP][31:0]} << sq_side[SSTEP][SSW-1:64];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_ax <= shx[31:0];
      sh_ay <= shy[31:0];
      sh_s  <= sq_q[SSTEP];
    end
  end

  // U = |p| * 2^(32+e) / S
  logic [31:0] ux_r [0:USTEP], ux_d [0:USTEP];
  logic [32:0] ux_n [0:USTEP], ux_q [0:USTEP];
  logic [31:0] uy_r [0:USTEP], uy_d [0:USTEP];
  logic [32:0] uy_n [0:USTEP], uy_q [0:USTEP];

  assign ux_r[0] = {1'b0, sh_ax[31:1]};
  assign ux_d[0] = sh_s;
  assign ux_n[0] = {sh_ax[0], 32'd0};
  assign ux_q[0] = '0;
  assign uy_r[0] = {1'b0, sh_ay[31:1]};
  assign uy_d[0] = sh_s;
  assign uy_n[0] = {sh_ay[0], 32'd0};
  assign uy_q[0] = '0;

  for (genvar k = 0; k < USTEP; k++) begin : g_udiv
    rmj_div_cell #(.DW(32), .NW(33), .QW(33)) u_x (
      .clk(clk), .en(en),
      .r_in(ux_r[k]), .d_in(ux_d[k]), .n_in(ux_n[k]), .q_in(ux_q[k]),
      .r_out(ux_r[k+1]), .d_out(ux_d[k+1]), .n_out(ux_n[k+1]), .q_out(ux_q[k+1])
    );
    rmj_div_cell #(.DW(32), .NW(33), .QW(33)) u_y (
      .clk(clk), .en(en),
      .r_in(uy_r[k]), .d_in(uy_d[k]), .n_in(uy_n[k]), .q_in(uy_q[k]),
      .r_out(uy_r[k+1]), .d_out(uy_d[k+1]), .n_out(uy_n[k+1]), .q_out(uy_q[k+1])
    );
  end

  // bearing quotients |p| * 2^(2F) / r2
  logic [63:0]    bx_r [0:BQW], bx_d [0:BQW];
  logic [BQW-1:0] bx_n [0:BQW], bx_q [0:BQW];
  logic [63:0]    by_r [0:BQW], by_d [0:BQW];
  logic [BQW-1:0] by_n [0:BQW], by_q [0:BQW];

  assign bx_r[0] = {33'd0, s2_apx[31:1]};
  assign bx_d[0] = s2_p;
  assign bx_n[0] = {s2_apx[0], {(BQW-1){1'b0}}};
  assign bx_q[0] = '0;
  assign by_r[0] = {33'd0, s2_apy[31:1]};
  assign by_d[0] = s2_p;
  assign by_n[0] = {s2_apy[0], {(BQW-1){1'b0}}};
  assign by_q[0] = '0;

  for (genvar k = 0; k < BQW; k++) begin : g_bdiv
    rmj_div_cell #(.DW(64), .NW(BQW), .QW(BQW)) u_x (
      .clk(clk), .en(en),
      .r_in(bx_r[k]), .d_in(bx_d[k]), .n_in(bx_n[k]), .q_in(bx_q[k]),
      .r_out(bx_r[k+1]), .d_out(bx_d[k+1]), .n_out(bx_n[k+1]), .q_out(bx_q[k+1])
    );
    rmj_div_cell #(.DW(64), .NW(BQW), .QW(BQW)) u_y (
      .clk(clk), .en(en),
      .r_in(by_r[k]), .d_in(by_d[k]), .n_in(by_n[k]), .q_in(by_q[k]),
      .r_out(by_r[k+1]), .d_out(by_d[k+1]), .n_out(by_n[k+1]), .q_out(by_q[k+1])
    );
  end

  // W = |C| * 2^F / r2, overflow when the quotient needs more than 64 bits
  logic [63:0] w_hi;
  logic        w3_ovf;
  logic [63:0] w0_r, w0_d, w0_n;
  logic [63:0] w_r [0:WSTEP], w_d [0:WSTEP], w_n [0:WSTEP], w_q [0:WSTEP];

  assign w_hi = s2_cmag >> (64 - FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      w3_ovf <= w_hi >= s2_p;
      w0_r   <= w_hi;
      w0_d   <= s2_p;
      w0_n   <= s2_cmag << FRAC_BITS;
    end
  end

  assign w_r[0] = w0_r;
  assign w_d[0] = w0_d;
  assign w_n[0] = w0_n;
  assign w_q[0] = '0;

  for (genvar k = 0; k < WSTEP; k++) begin : g_wdiv
    rmj_div_cell #(.DW(64), .NW(64), .QW(64)) u_cell (
      .clk(clk), .en(en),
      .r_in(w_r[k]), .d_in(w_d[k]), .n_in(w_n[k]), .q_in(w_q[k]),
      .r_out(w_r[k+1]), .d_out(w_d[k+1]), .n_out(w_n[k+1]), .q_out(w_q[k+1])
    );
  end

  // align side paths with the end of the main chain
  logic [63:0]          w_al;
  logic                 wovf_al;
  logic [2*BQW-1:0]     b_al;
  rmj_pkg::flags_t      fl_al;

  rmj_delay #(.W(64), .DEPTH(W_DLY)) u_wdly (
    .clk(clk), .en(en), .d(w_q[WSTEP]), .q(w_al)
  );
  rmj_delay #(.W(1), .DEPTH(WO_DLY)) u_wodly (
    .clk(clk), .en(en), .d(w3_ovf), .q(wovf_al)
  );
  rmj_delay #(.W(2*BQW), .DEPTH(B_DLY)) u_bdly (
    .clk(clk), .en(en), .d({bx_q[BQW], by_q[BQW]}), .q(b_al)
  );
  rmj_delay #(.W($bits(rmj_pkg::flags_t)), .DEPTH(F_DLY)) u_fdly (
    .clk(clk), .en(en), .d(s2_flags), .q(fl_al)
  );

  // products U * W split on the 32-bit halves of W
  logic [64:0]          pr_hx, pr_lx, pr_hy, pr_ly;
  logic                 pr_nzx, pr_nzy, pr_wovf;
  logic [FRAC_BITS:0]   pr_rx, pr_ry;
  logic [BQW-1:0]       pr_bx, pr_by;
  rmj_pkg::flags_t      pr_fl;

  always_ff @(posedge clk) begin
    if (en) begin
      pr_hx   <= ux_q[USTEP] * w_al[63:32];
      pr_lx   <= ux_q[USTEP] * w_al[31:0];
      pr_hy   <= uy_q[USTEP] * w_al[63:32];
      pr_ly   <= uy_q[USTEP] * w_al[31:0];
      pr_nzx  <= ux_q[USTEP] != '0;
      pr_nzy  <= uy_q[USTEP] != '0;
      pr_rx   <= ux_q[USTEP][32:RSH];
      pr_ry   <= uy_q[USTEP][32:RSH];
      pr_bx   <= b_al[2*BQW-1:BQW];
      pr_by   <= b_al[BQW-1:0];
      pr_wovf <= wovf_al;
      pr_fl   <= fl_al;
    end
  end

  // sum, saturate and pack
  logic [MW-1:0]  mx, my;
  rmj_pkg::pack_t e_rx, e_ry, e_bx, e_by, e_cx, e_cy;
  rmj_pkg::jac_t  jac_next;

  assign mx = MW'(pr_hx) + MW'(pr_lx[64:32]);
  assign my = MW'(pr_hy) + MW'(pr_ly[64:32]);

  always_comb begin
    e_rx = rmj_pkg::sat_pack(MW'(pr_rx), pr_fl.neg_x, 1'b0);
    e_ry = rmj_pkg::sat_pack(MW'(pr_ry), pr_fl.neg_y, 1'b0);
    e_by = rmj_pkg::sat_pack(MW'(pr_by), !pr_fl.neg_y, 1'b0);
    e_bx = rmj_pkg::sat_pack(MW'(pr_bx), pr_fl.neg_x, 1'b0);
    e_cy = rmj_pkg::sat_pack(my, pr_fl.neg_y != pr_fl.c_neg, pr_wovf && pr_nzy);
    e_cx = rmj_pkg::sat_pack(mx, pr_fl.neg_x == pr_fl.c_neg, pr_wovf && pr_nzx);
    if (pr_fl.zero) begin
      jac_next = '0;
      jac_next.zero_position = 1'b1;
    end else begin
      jac_next.range_dpx     = e_rx.val;
      jac_next.range_dpy     = e_ry.val;
      jac_next.bearing_dpx   = e_by.val;
      jac_next.bearing_dpy   = e_bx.val;
      jac_next.rate_dpx      = e_cy.val;
      jac_next.rate_dpy      = e_cx.val;
      jac_next.rate_dvx      = e_rx.val;
      jac_next.rate_dvy      = e_ry.val;
      jac_next.zero_position = 1'b0;
      jac_next.saturated     = e_rx.sat | e_ry.sat | e_bx.sat | e_by.sat
                               | e_cx.sat | e_cy.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      jac <= jac_next;
    end
  end

  logic zero_clean, dup_match;

  assign zero_clean = !jac.saturated && jac.range_dpx == '0 && jac.bearing_dpx == '0
                      && jac.rate_dpx == '0;
  assign dup_match  = jac.rate_dvx == jac.range_dpx && jac.rate_dvy == jac.range_dpy;

  `RMJ_IMPLIES(a_zero_clean, jac_valid && jac.zero_position, zero_clean, "zero result not clear")
  `RMJ_IMPLIES(a_dup_match, jac_valid, dup_match, "range-rate velocity partials differ")
  `RMJ_ALWAYS(a_stall_hold, !(jac_valid && !jac_ready && req_ready), "request taken in stall")

endmodule
